// ===== design/cotan_mass_element_emitter_top_assert.svh =====
// Assertion macros for the cotangent element emitter.
`ifndef COTAN_MASS_ELEMENT_EMITTER_TOP_ASSERT_SVH
`define COTAN_MASS_ELEMENT_EMITTER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define CMEE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cmee: implication check failed");
`define CMEE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cmee: next-cycle check failed");
`else
`define CMEE_ASSERT_IMPL(lbl, ante, cons)
`define CMEE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/cmee_pkg.sv =====
// Package with widths, codes and the multiply schedule of the cotangent element emitter.
`timescale 1ns / 1ps
package cmee_pkg;

  localparam int IdW        = 20;
  localparam int CoordW     = 32;
  localparam int DiffW      = CoordW + 1;
  localparam int OpW        = DiffW + 1;
  localparam int ProdW      = 2 * OpW;
  localparam int AccW       = 67;
  localparam int MagW       = 65;
  localparam int LoW        = 32;
  localparam int SqW        = 132;
  localparam int RootW      = SqW / 2;
  localparam int RemW       = RootW + 2;
  localparam int MassW      = 47;
  localparam int MassShift  = 19;
  localparam int MassSrcW   = 48;
  localparam int MassSteps  = MassSrcW / 2;
  localparam int CotW       = 32;
  localparam int QBits      = 31;
  localparam int CotShift   = 15;
  localparam int NumW       = AccW - 1 + CotShift;
  localparam int DshW       = RootW + QBits - 1;
  localparam int NumSteps   = 24;
  localparam int NumResults = 12;
  localparam int MaxPoints  = 1048576;
  localparam int QueueDepth = 2;

  typedef enum logic [3:0] {
    SRC_AX, SRC_AY, SRC_AZ,
    SRC_BX, SRC_BY, SRC_BZ,
    SRC_CX, SRC_CY, SRC_CZ,
    SRC_XLO, SRC_XHI, SRC_YLO, SRC_YHI, SRC_ZLO, SRC_ZHI
  } src_e;

  typedef enum logic [2:0] {
    DST_CX, DST_CY, DST_CZ, DST_D0, DST_D1, DST_D2, DST_SQ
  } dst_e;

  typedef enum logic [1:0] {
    SH_NONE, SH_MID, SH_HIGH
  } shift_e;

  typedef struct packed {
    src_e   a;
    src_e   b;
    dst_e   dst;
    logic   neg;
    shift_e sh;
  } step_t;

  typedef struct packed {
    logic [IdW-1:0]          id0;
    logic [IdW-1:0]          id1;
    logic [IdW-1:0]          id2;
    logic signed [DiffW-1:0] ax;
    logic signed [DiffW-1:0] ay;
    logic signed [DiffW-1:0] az;
    logic signed [DiffW-1:0] bx;
    logic signed [DiffW-1:0] by;
    logic signed [DiffW-1:0] bz;
    logic signed [DiffW-1:0] cx;
    logic signed [DiffW-1:0] cy;
    logic signed [DiffW-1:0] cz;
  } tri_t;

  typedef struct packed {
    logic [IdW-1:0]   id0;
    logic [IdW-1:0]   id1;
    logic [IdW-1:0]   id2;
    logic [MassW-1:0] mass;
    logic [CotW-1:0]  cot0;
    logic [CotW-1:0]  cot1;
    logic [CotW-1:0]  cot2;
    logic             degen;
  } elem_t;

  // Edge vectors are a = P1-P0, b = P2-P0 and c = P2-P1. The cross product is a x b,
  // the three corner dot products are b.c, a.b and -(a.c), and the last nine steps
  // square the cross components split into low and high halves.
  function automatic step_t step_of(input logic [4:0] s);
    step_t r;
    case (s)
      5'd0:    r = '{SRC_AY,  SRC_BZ,  DST_CX, 1'b0, SH_NONE};
      5'd1:    r = '{SRC_AZ,  SRC_BY,  DST_CX, 1'b1, SH_NONE};
      5'd2:    r = '{SRC_AZ,  SRC_BX,  DST_CY, 1'b0, SH_NONE};
      5'd3:    r = '{SRC_AX,  SRC_BZ,  DST_CY, 1'b1, SH_NONE};
      5'd4:    r = '{SRC_AX,  SRC_BY,  DST_CZ, 1'b0, SH_NONE};
      5'd5:    r = '{SRC_AY,  SRC_BX,  DST_CZ, 1'b1, SH_NONE};
      5'd6:    r = '{SRC_BX,  SRC_CX,  DST_D0, 1'b0, SH_NONE};
      5'd7:    r = '{SRC_BY,  SRC_CY,  DST_D0, 1'b0, SH_NONE};
      5'd8:    r = '{SRC_BZ,  SRC_CZ,  DST_D0, 1'b0, SH_NONE};
      5'd9:    r = '{SRC_AX,  SRC_BX,  DST_D1, 1'b0, SH_NONE};
      5'd10:   r = '{SRC_AY,  SRC_BY,  DST_D1, 1'b0, SH_NONE};
      5'd11:   r = '{SRC_AZ,  SRC_BZ,  DST_D1, 1'b0, SH_NONE};
      5'd12:   r = '{SRC_AX,  SRC_CX,  DST_D2, 1'b1, SH_NONE};
      5'd13:   r = '{SRC_AY,  SRC_CY,  DST_D2, 1'b1, SH_NONE};
      5'd14:   r = '{SRC_AZ,  SRC_CZ,  DST_D2, 1'b1, SH_NONE};
      5'd15:   r = '{SRC_XLO, SRC_XLO, DST_SQ, 1'b0, SH_NONE};
      5'd16:   r = '{SRC_XHI, SRC_XLO, DST_SQ, 1'b0, SH_MID};
      5'd17:   r = '{SRC_XHI, SRC_XHI, DST_SQ, 1'b0, SH_HIGH};
      5'd18:   r = '{SRC_YLO, SRC_YLO, DST_SQ, 1'b0, SH_NONE};
      5'd19:   r = '{SRC_YHI, SRC_YLO, DST_SQ, 1'b0, SH_MID};
      5'd20:   r = '{SRC_YHI, SRC_YHI, DST_SQ, 1'b0, SH_HIGH};
      5'd21:   r = '{SRC_ZLO, SRC_ZLO, DST_SQ, 1'b0, SH_NONE};
      5'd22:   r = '{SRC_ZHI, SRC_ZLO, DST_SQ, 1'b0, SH_MID};
      5'd23:   r = '{SRC_ZHI, SRC_ZHI, DST_SQ, 1'b0, SH_HIGH};
      default: r = '{SRC_AX,  SRC_AX,  DST_SQ, 1'b0, SH_NONE};
    endcase
    return r;
  endfunction

endpackage

// ===== design/cmee_if.sv =====
// Handshake interfaces for triangle transactions and element transactions.
`timescale 1ns / 1ps
interface cmee_tri_if import cmee_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IdW-1:0]           vert0_id;
  logic [IdW-1:0]           vert1_id;
  logic [IdW-1:0]           vert2_id;
  logic signed [CoordW-1:0] vert0_x;
  logic signed [CoordW-1:0] vert0_y;
  logic signed [CoordW-1:0] vert0_z;
  logic signed [CoordW-1:0] vert1_x;
  logic signed [CoordW-1:0] vert1_y;
  logic signed [CoordW-1:0] vert1_z;
  logic signed [CoordW-1:0] vert2_x;
  logic signed [CoordW-1:0] vert2_y;
  logic signed [CoordW-1:0] vert2_z;

  modport source (
    output valid, vert0_id, vert1_id, vert2_id,
    output vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
    output vert2_x, vert2_y, vert2_z,
    input  ready
  );
  modport sink (
    input  valid, vert0_id, vert1_id, vert2_id,
    input  vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
    input  vert2_x, vert2_y, vert2_z,
    output ready
  );
endinterface

interface cmee_res_if import cmee_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [IdW-1:0]         row_index;
  logic [IdW-1:0]         col_index;
  logic [MassW-1:0]       mass_value;
  logic signed [CotW-1:0] cotan_value;
  logic                   degenerate;
  logic                   last;

  modport source (
    output valid, row_index, col_index, mass_value, cotan_value, degenerate, last,
    input  ready
  );
  modport sink (
    input  valid, row_index, col_index, mass_value, cotan_value, degenerate, last,
    output ready
  );
endinterface

// ===== design/cmee_front.sv =====
// Front end: accepts triangles, drops those with an out-of-range id, forms edge vectors.
`timescale 1ns / 1ps
module cmee_front import cmee_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  cmee_tri_if.sink tri_i,
  output tri_t  tri_o,
  output logic  tri_valid_o,
  input  logic  tri_take_i
);

  localparam logic [31:0] IdLimit = 32'(MaxPoints);

  logic hold_valid_q, hold_valid_d;
  tri_t tri_q, tri_d;
  logic accept, ids_ok;

  assign tri_i.ready = !hold_valid_q;
  assign accept      = tri_i.valid && tri_i.ready;
  assign ids_ok      = (32'(tri_i.vert0_id) < IdLimit) && (32'(tri_i.vert1_id) < IdLimit)
                    && (32'(tri_i.vert2_id) < IdLimit);

  always_comb begin
    tri_d.id0 = tri_i.vert0_id;
    tri_d.id1 = tri_i.vert1_id;
    tri_d.id2 = tri_i.vert2_id;
    tri_d.ax  = DiffW'(tri_i.vert1_x) - DiffW'(tri_i.vert0_x);
    tri_d.ay  = DiffW'(tri_i.vert1_y) - DiffW'(tri_i.vert0_y);
    tri_d.az  = DiffW'(tri_i.vert1_z) - DiffW'(tri_i.vert0_z);
    tri_d.bx  = DiffW'(tri_i.vert2_x) - DiffW'(tri_i.vert0_x);
    tri_d.by  = DiffW'(tri_i.vert2_y) - DiffW'(tri_i.vert0_y);
    tri_d.bz  = DiffW'(tri_i.vert2_z) - DiffW'(tri_i.vert0_z);
    tri_d.cx  = DiffW'(tri_i.vert2_x) - DiffW'(tri_i.vert1_x);
    tri_d.cy  = DiffW'(tri_i.vert2_y) - DiffW'(tri_i.vert1_y);
    tri_d.cz  = DiffW'(tri_i.vert2_z) - DiffW'(tri_i.vert1_z);
  end

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (accept && ids_ok) begin
      hold_valid_d = 1'b1;
    end else if (tri_take_i) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tri_q <= tri_d;
    end
  end

  assign tri_o       = tri_q;
  assign tri_valid_o = hold_valid_q;

endmodule

// ===== design/cmee_calc.sv =====
// Geometry engine: shared multiplier schedule, bit-serial square root and quotient lanes.
`timescale 1ns / 1ps
module cmee_calc import cmee_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  tri_t  tri_i,
  input  logic  tri_valid_i,
  output logic  tri_take_o,
  output elem_t elem_o,
  output logic  elem_valid_o,
  input  logic  elem_ready_i
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ROOT, S_PREP, S_DIV, S_DONE} state_e;

  state_e state_q, state_d;
  logic [4:0] step_q, step_d;
  logic       pvalid_q, pvalid_d;
  logic [6:0] cnt_q, cnt_d;

  tri_t  tri_q, tri_d;
  step_t pstep_q, pstep_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [AccW-1:0]  crs_q [3];
  logic signed [AccW-1:0]  crs_d [3];
  logic signed [AccW-1:0]  dot_q [3];
  logic signed [AccW-1:0]  dot_d [3];
  logic [MagW-1:0]         mag_q [3];
  logic [SqW-1:0]          sq_q, sq_d;
  logic [SqW-1:0]          sshift_q, sshift_d;
  logic [RemW-1:0]         srem_q, srem_d;
  logic [RootW-1:0]        root_q, root_d;
  logic [DshW-1:0]         dsh_q, dsh_d;
  logic [NumW-1:0]         rem_q [3];
  logic [NumW-1:0]         rem_d [3];
  logic [QBits-1:0]        quo_q [3];
  logic [QBits-1:0]        quo_d [3];
  logic                    neg_q [3];
  logic                    neg_d [3];
  logic [MassSrcW-1:0]     msrc_q, msrc_d;
  logic [MassSrcW-1:0]     mquo_q, mquo_d;
  logic [1:0]              mrem_q, mrem_d;
  logic                    degen_q, degen_d;

  step_t                   cur_step;
  logic signed [OpW-1:0]   op_a, op_b;
  logic signed [AccW-1:0]  pval;
  logic [SqW-1:0]          pext;
  logic [RemW-1:0]         rem2, trial;
  logic [3:0]              mv;
  logic [1:0]              mdig;
  logic [DshW-1:0]         lane_ext [3];
  logic signed [AccW-1:0]  dabs [3];
  logic [CotW-1:0]         cot_pos [3];

  function automatic logic signed [OpW-1:0] operand(input src_e s, input tri_t t,
                                                    input logic [MagW-1:0] mx,
                                                    input logic [MagW-1:0] my,
                                                    input logic [MagW-1:0] mz);
    logic signed [OpW-1:0] r;
    case (s)
      SRC_AX:  r = OpW'(t.ax);
      SRC_AY:  r = OpW'(t.ay);
      SRC_AZ:  r = OpW'(t.az);
      SRC_BX:  r = OpW'(t.bx);
      SRC_BY:  r = OpW'(t.by);
      SRC_BZ:  r = OpW'(t.bz);
      SRC_CX:  r = OpW'(t.cx);
      SRC_CY:  r = OpW'(t.cy);
      SRC_CZ:  r = OpW'(t.cz);
      SRC_XLO: r = {2'b00, mx[LoW-1:0]};
      SRC_XHI: r = {1'b0, mx[MagW-1:LoW]};
      SRC_YLO: r = {2'b00, my[LoW-1:0]};
      SRC_YHI: r = {1'b0, my[MagW-1:LoW]};
      SRC_ZLO: r = {2'b00, mz[LoW-1:0]};
      SRC_ZHI: r = {1'b0, mz[MagW-1:LoW]};
      default: r = '0;
    endcase
    return r;
  endfunction

  assign cur_step = step_of(step_q);
  assign op_a     = operand(cur_step.a, tri_q, mag_q[0], mag_q[1], mag_q[2]);
  assign op_b     = operand(cur_step.b, tri_q, mag_q[0], mag_q[1], mag_q[2]);
  assign prod_d   = ProdW'(op_a) * ProdW'(op_b);
  assign pval     = prod_q[AccW-1:0];
  assign pext     = {{(SqW-ProdW+1){1'b0}}, prod_q[ProdW-2:0]};
  assign rem2     = {srem_q[RemW-3:0], sshift_q[SqW-1:SqW-2]};
  assign trial    = {root_q, 2'b01};
  assign mv       = {mrem_q, msrc_q[MassSrcW-1:MassSrcW-2]};
  assign mdig     = (mv >= 4'd9) ? 2'd3 : (mv >= 4'd6) ? 2'd2 : (mv >= 4'd3) ? 2'd1 : 2'd0;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      lane_ext[l] = DshW'(rem_q[l]);
      dabs[l]     = dot_q[l][AccW-1] ? -dot_q[l] : dot_q[l];
      cot_pos[l]  = neg_q[l] ? -{1'b0, quo_q[l]} : {1'b0, quo_q[l]};
    end
  end

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    pvalid_d = 1'b0;
    pstep_d  = pstep_q;
    cnt_d    = cnt_q;
    tri_d    = tri_q;
    crs_d    = crs_q;
    dot_d    = dot_q;
    sq_d     = sq_q;
    sshift_d = sshift_q;
    srem_d   = srem_q;
    root_d   = root_q;
    dsh_d    = dsh_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    neg_d    = neg_q;
    msrc_d   = msrc_q;
    mquo_d   = mquo_q;
    mrem_d   = mrem_q;
    degen_d  = degen_q;
    tri_take_o   = 1'b0;
    elem_valid_o = 1'b0;

    if (pvalid_q) begin
      case (pstep_q.dst)
        DST_CX:  crs_d[0] = pstep_q.neg ? crs_q[0] - pval : crs_q[0] + pval;
        DST_CY:  crs_d[1] = pstep_q.neg ? crs_q[1] - pval : crs_q[1] + pval;
        DST_CZ:  crs_d[2] = pstep_q.neg ? crs_q[2] - pval : crs_q[2] + pval;
        DST_D0:  dot_d[0] = pstep_q.neg ? dot_q[0] - pval : dot_q[0] + pval;
        DST_D1:  dot_d[1] = pstep_q.neg ? dot_q[1] - pval : dot_q[1] + pval;
        DST_D2:  dot_d[2] = pstep_q.neg ? dot_q[2] - pval : dot_q[2] + pval;
        DST_SQ: begin
          case (pstep_q.sh)
            SH_MID:  sq_d = sq_q + (pext << 33);
            SH_HIGH: sq_d = sq_q + (pext << 64);
            default: sq_d = sq_q + pext;
          endcase
        end
        default: sq_d = sq_q;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (tri_valid_i) begin
          tri_take_o = 1'b1;
          tri_d      = tri_i;
          step_d     = '0;
          sq_d       = '0;
          for (int l = 0; l < 3; l++) begin
            crs_d[l] = '0;
            dot_d[l] = '0;
          end
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (step_q < 5'(NumSteps)) begin
          pvalid_d = 1'b1;
          pstep_d  = cur_step;
          step_d   = step_q + 5'd1;
        end else if (!pvalid_q) begin
          sshift_d = sq_q;
          srem_d   = '0;
          root_d   = '0;
          cnt_d    = '0;
          state_d  = S_ROOT;
        end
      end
      S_ROOT: begin
        if (rem2 >= trial) begin
          srem_d = rem2 - trial;
          root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          srem_d = rem2;
          root_d = {root_q[RootW-2:0], 1'b0};
        end
        sshift_d = sshift_q << 2;
        cnt_d    = cnt_q + 7'd1;
        if (cnt_q == 7'(RootW - 1)) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        dsh_d   = DshW'(root_q) << (QBits - 1);
        msrc_d  = {1'b0, root_q[RootW-1:MassShift]};
        mquo_d  = '0;
        mrem_d  = '0;
        degen_d = (root_q == '0);
        for (int l = 0; l < 3; l++) begin
          rem_d[l] = {dabs[l][AccW-2:0], {CotShift{1'b0}}};
          quo_d[l] = '0;
          neg_d[l] = dot_q[l][AccW-1];
        end
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        for (int l = 0; l < 3; l++) begin
          if (lane_ext[l] >= dsh_q) begin
            rem_d[l] = NumW'(lane_ext[l] - dsh_q);
            quo_d[l] = {quo_q[l][QBits-2:0], 1'b1};
          end else begin
            quo_d[l] = {quo_q[l][QBits-2:0], 1'b0};
          end
        end
        dsh_d = dsh_q >> 1;
        if (cnt_q < 7'(MassSteps)) begin
          mquo_d = {mquo_q[MassSrcW-3:0], mdig};
          mrem_d = 2'(mv - 4'(3 * mdig));
          msrc_d = msrc_q << 2;
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(QBits - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        elem_valid_o = 1'b1;
        if (elem_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= '0;
      pvalid_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      pvalid_q <= pvalid_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tri_q    <= tri_d;
    pstep_q  <= pstep_d;
    prod_q   <= prod_d;
    crs_q    <= crs_d;
    dot_q    <= dot_d;
    sq_q     <= sq_d;
    sshift_q <= sshift_d;
    srem_q   <= srem_d;
    root_q   <= root_d;
    dsh_q    <= dsh_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    neg_q    <= neg_d;
    msrc_q   <= msrc_d;
    mquo_q   <= mquo_d;
    mrem_q   <= mrem_d;
    degen_q  <= degen_d;
    for (int l = 0; l < 3; l++) begin
      mag_q[l] <= crs_q[l][AccW-1] ? MagW'(-crs_q[l]) : MagW'(crs_q[l]);
    end
  end

  assign elem_o.id0   = tri_q.id0;
  assign elem_o.id1   = tri_q.id1;
  assign elem_o.id2   = tri_q.id2;
  assign elem_o.mass  = mquo_q[MassW-1:0];
  assign elem_o.cot0  = cot_pos[0];
  assign elem_o.cot1  = cot_pos[1];
  assign elem_o.cot2  = cot_pos[2];
  assign elem_o.degen = degen_q;

endmodule

// ===== design/cmee_fifo.sv =====
// Short queue of finished triangle records between the engine and the emitter.
`timescale 1ns / 1ps
module cmee_fifo import cmee_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  elem_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output elem_t data_o,
  output logic  empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  elem_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/cmee_back.sv =====
// Back end: expands one triangle record into twelve matrix element transactions.
`timescale 1ns / 1ps
module cmee_back import cmee_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  elem_t elem_i,
  input  logic  empty_i,
  output logic  pop_o,
  cmee_res_if.source res_o
);

  logic       have_q, have_d;
  logic [3:0] idx_q, idx_d;
  logic       ovalid_q, ovalid_d;
  elem_t      cur_q;
  logic       out_free, emit, finish;

  logic [IdW-1:0]   id_i, id_j, row_d, col_d;
  logic [CotW-1:0]  pos, cot_d;
  logic [IdW-1:0]   row_q, col_q;
  logic [MassW-1:0] mass_q;
  logic [CotW-1:0]  cot_q;
  logic             degen_q, last_q;

  assign out_free = !ovalid_q || res_o.ready;
  assign emit     = have_q && out_free;
  assign finish   = emit && (idx_q == 4'(NumResults - 1));
  assign pop_o    = (!have_q || finish) && !empty_i;

  always_comb begin
    case (idx_q[3:2])
      2'd0: begin
        id_i = cur_q.id0;
        id_j = cur_q.id1;
        pos  = cur_q.cot0;
      end
      2'd1: begin
        id_i = cur_q.id1;
        id_j = cur_q.id2;
        pos  = cur_q.cot1;
      end
      default: begin
        id_i = cur_q.id2;
        id_j = cur_q.id0;
        pos  = cur_q.cot2;
      end
    endcase
    case (idx_q[1:0])
      2'd0: begin
        row_d = id_i;
        col_d = id_j;
      end
      2'd1: begin
        row_d = id_j;
        col_d = id_i;
      end
      2'd2: begin
        row_d = id_i;
        col_d = id_i;
      end
      default: begin
        row_d = id_j;
        col_d = id_j;
      end
    endcase
    cot_d = idx_q[1] ? -pos : pos;
  end

  always_comb begin
    have_d   = have_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    if (res_o.ready) begin
      ovalid_d = 1'b0;
    end
    if (emit) begin
      ovalid_d = 1'b1;
      idx_d    = idx_q + 4'd1;
    end
    if (finish) begin
      have_d = 1'b0;
    end
    if (pop_o) begin
      have_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q   <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      have_q   <= have_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= elem_i;
    end
    if (emit) begin
      row_q   <= row_d;
      col_q   <= col_d;
      mass_q  <= cur_q.mass;
      cot_q   <= cot_d;
      degen_q <= cur_q.degen;
      last_q  <= (idx_q == 4'(NumResults - 1));
    end
  end

  assign res_o.valid       = ovalid_q;
  assign res_o.row_index   = row_q;
  assign res_o.col_index   = col_q;
  assign res_o.mass_value  = mass_q;
  assign res_o.cotan_value = cot_q;
  assign res_o.degenerate  = degen_q;
  assign res_o.last        = last_q;

endmodule

// ===== design/cotan_mass_element_emitter_top.sv =====
// Top level of the cotangent Laplacian and mass element emitter.
//
//   Port   Direction  Transaction
//   tri_i  in         one triangle: three point ids and nine Q16.16 coordinates
//   res_o  out        one matrix element: row, column, mass, cotangent, flags
//
// A taken triangle holds the engine through the shared multiplier schedule, the square root,
// a setup step and the quotient lanes until it is handed to the queue; only then does the
// engine take a new one. The front holds one further triangle and the queue two finished
// ones, as the emitter sends twelve elements at one per cycle while the output is ready.
// Reset is asynchronous and clears control state only. An output stall fills the queue and
// then holds the engine; triangles with an out-of-range point id are dropped.
`timescale 1ns / 1ps
`include "cotan_mass_element_emitter_top_assert.svh"
module cotan_mass_element_emitter_top import cmee_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  cmee_tri_if.sink   tri_i,
  cmee_res_if.source res_o
);

  tri_t  tri_hold;
  logic  hold_valid, calc_take;
  elem_t elem_calc, elem_head;
  logic  elem_valid, q_full, q_empty, q_pop;

  cmee_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tri_i       (tri_i),
    .tri_o       (tri_hold),
    .tri_valid_o (hold_valid),
    .tri_take_i  (calc_take)
  );

  cmee_calc u_calc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tri_i        (tri_hold),
    .tri_valid_i  (hold_valid),
    .tri_take_o   (calc_take),
    .elem_o       (elem_calc),
    .elem_valid_o (elem_valid),
    .elem_ready_i (!q_full)
  );

  cmee_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (elem_valid),
    .data_i  (elem_calc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (elem_head),
    .empty_o (q_empty)
  );

  cmee_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .elem_i  (elem_head),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .res_o   (res_o)
  );

  `CMEE_ASSERT_IMPL(a_take_needs_hold, calc_take, hold_valid)
  `CMEE_ASSERT_NEXT(a_take_frees_front, calc_take, tri_i.ready)
  `CMEE_ASSERT_IMPL(a_pop_needs_data, q_pop, !q_empty)
  `CMEE_ASSERT_IMPL(a_degen_zero_mass, res_o.valid && res_o.degenerate, res_o.mass_value == '0)

endmodule

// ===== sim/cmee_scoreboard.sv =====
// Checker that predicts the matrix elements of each accepted triangle and compares them.
`timescale 1ns / 1ps
module cmee_scoreboard import cmee_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  cmee_tri_if  tri_w,
  cmee_res_if  res_w,
  output int   fail_count,
  output int   pending,
  output int   elems_seen,
  output int   degen_seen
);

  typedef struct packed {
    logic [IdW-1:0]         row;
    logic [IdW-1:0]         col;
    logic [MassW-1:0]       mass;
    logic signed [CotW-1:0] cot;
    logic                   degen;
    logic                   last;
  } elem_exp_t;

  typedef logic signed [159:0] big_t;

  elem_exp_t elem_q[$];

  function automatic big_t abs_big(input big_t v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic predict_triangle();
    logic [IdW-1:0] id [3];
    big_t p [3][3];
    big_t e1 [3];
    big_t e2 [3];
    big_t cx, cy, cz, sq, root, cand, mq, dot, quo;
    logic [CotW-1:0] mag, pos;
    logic degen;
    logic [MassW-1:0] mass;
    elem_exp_t e;
    int j, k, n;
    id[0] = tri_w.vert0_id;
    id[1] = tri_w.vert1_id;
    id[2] = tri_w.vert2_id;
    p[0][0] = tri_w.vert0_x; p[0][1] = tri_w.vert0_y; p[0][2] = tri_w.vert0_z;
    p[1][0] = tri_w.vert1_x; p[1][1] = tri_w.vert1_y; p[1][2] = tri_w.vert1_z;
    p[2][0] = tri_w.vert2_x; p[2][1] = tri_w.vert2_y; p[2][2] = tri_w.vert2_z;
    for (int d = 0; d < 3; d++) begin
      e1[d] = p[1][d] - p[0][d];
      e2[d] = p[2][d] - p[0][d];
    end
    cx = abs_big(e1[1] * e2[2] - e1[2] * e2[1]);
    cy = abs_big(e1[2] * e2[0] - e1[0] * e2[2]);
    cz = abs_big(e1[0] * e2[1] - e1[1] * e2[0]);
    sq = cx * cx + cy * cy + cz * cz;
    root = 0;
    for (int b = 67; b >= 0; b--) begin
      cand = root | (big_t'(1) << b);
      if (cand * cand <= sq) root = cand;
    end
    degen = (root == 0);
    mq = root / 1572864;
    if (mq > big_t'(47'h7FFF_FFFF_FFFF)) mq = big_t'(47'h7FFF_FFFF_FFFF);
    mass = mq[MassW-1:0];
    n = 0;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      dot = 0;
      for (int d = 0; d < 3; d++) dot += (p[i][d] - p[k][d]) * (p[j][d] - p[k][d]);
      if (degen) begin
        mag = 32'h7FFF_FFFF;
      end else begin
        quo = (abs_big(dot) <<< 15) / root;
        mag = (quo > 160'sh7FFF_FFFF) ? 32'h7FFF_FFFF : quo[CotW-1:0];
      end
      pos = (dot < 0) ? -mag : mag;
      for (int r = 0; r < 4; r++) begin
        e.row   = (r == 0 || r == 2) ? id[i] : id[j];
        e.col   = (r == 0) ? id[j] : (r == 3) ? id[j] : id[i];
        e.mass  = mass;
        e.cot   = (r < 2) ? pos : -pos;
        e.degen = degen;
        e.last  = (n == 11);
        elem_q.push_back(e);
        n++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    elem_exp_t e;
    if (!rst_ni) begin
      elem_q.delete();
      fail_count <= 0;
      elems_seen <= 0;
      degen_seen <= 0;
    end else begin
      if (tri_w.valid && tri_w.ready) predict_triangle();
      if (res_w.valid && res_w.ready) begin
        elems_seen <= elems_seen + 1;
        if (res_w.degenerate) degen_seen <= degen_seen + 1;
        if (elem_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected element transaction row %0d col %0d",
                                        res_w.row_index, res_w.col_index);
          fail_count <= fail_count + 1;
        end else begin
          e = elem_q.pop_front();
          if (res_w.row_index !== e.row || res_w.col_index !== e.col ||
              res_w.mass_value !== e.mass || res_w.cotan_value !== e.cot ||
              res_w.degenerate !== e.degen || res_w.last !== e.last) begin
            if (fail_count < 10) begin
              $display("mismatch exp row %0d col %0d mass %0d cot %0d dg %0b last %0b",
                       e.row, e.col, e.mass, e.cot, e.degen, e.last);
              $display("         got row %0d col %0d mass %0d cot %0d dg %0b last %0b",
                       res_w.row_index, res_w.col_index, res_w.mass_value,
                       res_w.cotan_value, res_w.degenerate, res_w.last);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  always_comb pending = elem_q.size();

endmodule

// ===== sim/cotan_mass_element_emitter_top_test.sv =====
// Top of the testbench: drives triangles and result stalls and reports the verdict.
`timescale 1ns / 1ps
module cotan_mass_element_emitter_top_test;
  import cmee_pkg::*;

  localparam int NumDirected = 20;
  localparam int NumRandom   = 290;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, elems_seen, degen_seen;
  int   idle_pct_in = 0;
  int   idle_pct_out = 0;

  cmee_tri_if tri_w ();
  cmee_res_if res_w ();

  cotan_mass_element_emitter_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tri_i (tri_w.sink),
    .res_o (res_w.source)
  );

  cmee_scoreboard checker_u (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tri_w     (tri_w),
    .res_w     (res_w),
    .fail_count(fail_count),
    .pending   (pending),
    .elems_seen(elems_seen),
    .degen_seen(degen_seen)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    res_w.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    res_w.ready <= ($urandom_range(99) >= idle_pct_out);
  end

  task automatic send_triangle(input logic [IdW-1:0] i0, i1, i2,
                               input logic [CoordW-1:0] c [9]);
    while ($urandom_range(99) < idle_pct_in) begin
      tri_w.valid <= 1'b0;
      @(posedge clk_i);
    end
    tri_w.valid    <= 1'b1;
    tri_w.vert0_id <= i0;
    tri_w.vert1_id <= i1;
    tri_w.vert2_id <= i2;
    tri_w.vert0_x <= c[0]; tri_w.vert0_y <= c[1]; tri_w.vert0_z <= c[2];
    tri_w.vert1_x <= c[3]; tri_w.vert1_y <= c[4]; tri_w.vert1_z <= c[5];
    tri_w.vert2_x <= c[6]; tri_w.vert2_y <= c[7]; tri_w.vert2_z <= c[8];
    @(posedge clk_i);
    while (!tri_w.ready) @(posedge clk_i);
  endtask

  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      2:       return $urandom_range(32'h0100_0000) - 32'h0080_0000;
      default: return $urandom_range(32'h0000_4000) - 32'h0000_2000;
    endcase
  endfunction

  initial begin
    logic [CoordW-1:0] c [9];
    logic [IdW-1:0] ids [3];
    tri_w.valid = 1'b0;
    tri_w.vert0_id = '0; tri_w.vert1_id = '0; tri_w.vert2_id = '0;
    tri_w.vert0_x = '0; tri_w.vert0_y = '0; tri_w.vert0_z = '0;
    tri_w.vert1_x = '0; tri_w.vert1_y = '0; tri_w.vert1_z = '0;
    tri_w.vert2_x = '0; tri_w.vert2_y = '0; tri_w.vert2_z = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed triangles: right angle, extreme ids and coordinates, zero area cases,
    // a very thin triangle whose cotangent saturates, and repeated ids.
    for (int t = 0; t < NumDirected; t++) begin
      for (int m = 0; m < 9; m++) c[m] = '0;
      ids[0] = IdW'(t); ids[1] = IdW'(t + 1); ids[2] = IdW'(t + 2);
      case (t)
        0: begin c[3] = 32'h0001_0000; c[7] = 32'h0001_0000; end
        1: begin
          ids[0] = '0; ids[1] = '1; ids[2] = 20'h80000;
          c[0] = 32'h8000_0000; c[1] = 32'h8000_0000; c[2] = 32'h8000_0000;
          c[3] = 32'h7FFF_FFFF; c[4] = 32'h8000_0000; c[5] = 32'h7FFF_FFFF;
          c[6] = 32'h8000_0000; c[7] = 32'h7FFF_FFFF; c[8] = 32'h7FFF_FFFF;
        end
        2: ;
        3: begin c[3] = 32'h0002_0000; c[6] = 32'h0004_0000; end
        4: begin c[0] = 32'h1234_5678; c[3] = 32'h1234_5678; c[6] = 32'h1234_5678; end
        5: begin c[3] = 32'h4000_0000; c[6] = 32'h2000_0000; c[7] = 32'h0000_0001; end
        6: begin c[3] = 32'h7FFF_FFFF; c[6] = 32'h8000_0000; c[8] = 32'h0000_0001; end
        7: begin
          ids[1] = ids[0]; ids[2] = ids[0];
          c[3] = 32'h0003_0000; c[8] = 32'h0001_0000;
        end
        8: begin
          c[0] = 32'h7FFF_FFFF; c[1] = 32'h7FFF_FFFF; c[2] = 32'h7FFF_FFFF;
          c[3] = 32'h8000_0000; c[4] = 32'h8000_0000; c[5] = 32'h8000_0000;
          c[6] = 32'h8000_0000; c[7] = 32'h7FFF_FFFF; c[8] = 32'h8000_0000;
        end
        9: begin c[3] = 32'h0001_0000; c[6] = 32'h0000_8000; c[7] = 32'h0000_DDB4; end
        default: for (int m = 0; m < 9; m++) c[m] = rand_coord();
      endcase
      send_triangle(ids[0], ids[1], ids[2], c);
    end

    for (int t = 0; t < NumRandom; t++) begin
      case (t * 4 / NumRandom)
        0: begin idle_pct_in = 0;  idle_pct_out = 0;  end
        1: begin idle_pct_in = 64; idle_pct_out = 0;  end
        2: begin idle_pct_in = 0;  idle_pct_out = 64; end
        default: begin idle_pct_in = 17; idle_pct_out = 17; end
      endcase
      for (int m = 0; m < 9; m++) c[m] = rand_coord();
      if ($urandom_range(9) == 0) begin
        for (int m = 0; m < 3; m++) c[6 + m] = 2 * c[3 + m] - c[m];
      end
      if ($urandom_range(19) == 0) begin
        for (int m = 0; m < 3; m++) c[3 + m] = c[m];
      end
      send_triangle(IdW'($urandom()), IdW'($urandom()), IdW'($urandom()), c);
    end
    tri_w.valid <= 1'b0;
    idle_pct_out = 0;

    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d triangles under four idle and stall mixes; %0d element transactions",
             NumDirected + NumRandom, elems_seen);
    $display("were checked, %0d of them flagged degenerate.", degen_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Run timed out with %0d element transactions outstanding.", pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/cmee_pkg.sv
design/cmee_if.sv
design/cmee_front.sv
design/cmee_calc.sv
design/cmee_fifo.sv
design/cmee_back.sv
design/cotan_mass_element_emitter_top.sv
sim/cmee_scoreboard.sv
sim/cotan_mass_element_emitter_top_test.sv
